@@ src/bta_pkg.sv @@
// shared constants and codes for the boundary tag heap allocator
package bta_pkg;

  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned TagWords  = HeapBytes / 4;
  localparam int unsigned WordAw    = $clog2(TagWords);
  localparam int unsigned PtrW      = $clog2(HeapBytes) + 1;  // byte pointer, holds HeapBytes
  localparam int unsigned TagW      = PtrW;                   // size | allocated flag
  localparam int unsigned ChunkInit = 4096;

  localparam logic [PtrW-1:0] MinBlock   = PtrW'(16);
  localparam logic [PtrW-1:0] ListStart  = PtrW'(8);
  localparam logic [16:0]     ChunkReset = 17'(ChunkInit);

  // heap image after reset: prologue, one free chunk, epilogue
  localparam logic [PtrW-1:0] BreakReset   = PtrW'(16 + ChunkInit);
  localparam logic [WordAw-1:0] ProHdrWord = WordAw'(1);
  localparam logic [WordAw-1:0] ProFtrWord = WordAw'(2);
  localparam logic [WordAw-1:0] ChkHdrWord = WordAw'(3);
  localparam logic [WordAw-1:0] ChkFtrWord = WordAw'((16 + ChunkInit - 8) / 4);
  localparam logic [WordAw-1:0] EpiWord    = WordAw'((16 + ChunkInit - 4) / 4);
  localparam logic [TagW-1:0]   ProTag     = TagW'(9);
  localparam logic [TagW-1:0]   ChunkTag   = TagW'(ChunkInit);
  localparam logic [TagW-1:0]   EpiTag     = TagW'(1);

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatZeroSize = 2'd1;
  localparam logic [1:0] StatNoMem    = 2'd2;

endpackage

@@ src/boundary_tag_heap_allocator.sv @@
// boundary tag heap allocator: next fit search, split, grow and coalesce over one tag memory
//
// One command at a time: start_i is taken while busy_o is low, and the result appears on
// result_offset_o/status_o for the single cycle that done_o is high; the receiver cannot stall.
// All tag traffic goes through one single-port tag memory (one read or write per cycle, read
// data registered), so the command time is set by that port. An allocate visits tags in its
// search, the zero-size epilogue tag included, then may grow, merge and split before the
// result strobe. After reset the tag memory is initialized by a pass over all its words,
// one word per cycle, during which busy_o is high; register writes are taken meanwhile.
module boundary_tag_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [15:0] request_bytes_i,
  input  logic [15:0] block_offset_i,
  output logic        done_o,
  output logic [15:0] result_offset_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PW = bta_pkg::PtrW;
  localparam int unsigned AW = bta_pkg::WordAw;
  localparam int unsigned TW = bta_pkg::TagW;

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE  = 5'd1,  S_A_RD  = 5'd2,  S_A_CHK = 5'd3,
                         S_G_CHK = 5'd4,  S_G_W1  = 5'd5,  S_G_W2  = 5'd6,  S_G_W3  = 5'd7,
                         S_M_RDP = 5'd8,  S_M_RDN = 5'd9,  S_M_CHK = 5'd10, S_M_WH  = 5'd11,
                         S_M_WF  = 5'd12, S_C_W1  = 5'd13, S_C_W2  = 5'd14, S_C_W3  = 5'd15,
                         S_C_W4  = 5'd16, S_F_RD  = 5'd17, S_F_CHK = 5'd18, S_F_WH  = 5'd19,
                         S_F_WF  = 5'd20, S_DONE  = 5'd21;

  logic [4:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [PW-1:0] bp_q, bp_d;
  logic [PW-1:0] size_q, size_d;
  logic [PW-1:0] need_q, need_d;
  logic [TW-1:0] prev_q, prev_d;
  logic [15:0]   rover_q, rover_d;
  logic [PW-1:0] brk_q, brk_d;
  logic [16:0]   chunk_q;
  logic          pass2_q, pass2_d;
  logic          free_q, free_d;
  logic [15:0]   res_q, res_d;
  logic [1:0]    stat_q, stat_d;
  logic          done_q, done_d;

  logic [TW-1:0] heap_mem [bta_pkg::TagWords];
  logic [TW-1:0] rd_q;
  logic          mem_we;
  logic [PW-1:0] mem_ab;
  logic [AW-1:0] mem_idx;
  logic [TW-1:0] mem_wd;

  logic [PW-1:0] rd_size, psz, merge_bp, merge_sz, rem_sz;
  logic          rd_used, pfree, nfree, split;
  logic [PW-1:0] gbytes;
  logic [PW:0]   gsize, gend;
  logic [PW-1:0] off_ext, rov_ext;

  assign rd_size  = {rd_q[TW-1:3], 3'b000};
  assign rd_used  = rd_q[0];
  assign psz      = {prev_q[TW-1:3], 3'b000};
  assign pfree    = !prev_q[0] && (psz != '0);
  assign nfree    = !rd_used;
  assign merge_bp = bp_q - (pfree ? psz : '0);
  assign merge_sz = size_q + (nfree ? rd_size : '0) + (pfree ? psz : '0);
  assign rem_sz   = size_q - need_q;
  assign split    = rem_sz >= bta_pkg::MinBlock;
  assign gbytes   = (need_q > chunk_q) ? need_q : chunk_q;
  // round the growth to an even count of words
  assign gsize    = {1'b0, gbytes[PW-1:3], 3'b000} + (gbytes[2] ? (PW+1)'(8) : '0);
  assign gend     = {1'b0, brk_q} + gsize;
  assign off_ext  = {1'b0, block_offset_i};
  assign rov_ext  = {1'b0, rover_q};
  assign mem_idx  = mem_ab[AW+1:2];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    bp_d    = bp_q;
    size_d  = size_q;
    need_d  = need_q;
    prev_d  = prev_q;
    rover_d = rover_q;
    brk_d   = brk_q;
    pass2_d = pass2_q;
    free_d  = free_q;
    res_d   = res_q;
    stat_d  = stat_q;
    done_d  = 1'b0;
    mem_we  = 1'b0;
    mem_ab  = bp_q - PW'(4);
    mem_wd  = size_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_ab = {1'b0, clr_q, 2'b00};
        if (clr_q == bta_pkg::ProHdrWord || clr_q == bta_pkg::ProFtrWord) begin
          mem_wd = bta_pkg::ProTag;
        end else if (clr_q == bta_pkg::ChkHdrWord || clr_q == bta_pkg::ChkFtrWord) begin
          mem_wd = bta_pkg::ChunkTag;
        end else if (clr_q == bta_pkg::EpiWord) begin
          mem_wd = bta_pkg::EpiTag;
        end else begin
          mem_wd = '0;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          stat_d = bta_pkg::StatOk;
          if (command_i == bta_pkg::CmdFree) begin
            free_d = 1'b1;
            bp_d   = off_ext;
            if (block_offset_i[2:0] != 3'b000 || off_ext < bta_pkg::MinBlock
                || off_ext >= brk_q) begin
              state_d = S_DONE;
            end else begin
              state_d = S_F_RD;
            end
          end else if (request_bytes_i == '0) begin
            stat_d  = bta_pkg::StatZeroSize;
            state_d = S_DONE;
          end else begin
            free_d  = 1'b0;
            pass2_d = 1'b0;
            bp_d    = rov_ext;
            need_d  = (request_bytes_i <= 16'd8) ? bta_pkg::MinBlock
                    : (({1'b0, request_bytes_i} + PW'(15)) & ~PW'(7));
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        if (pass2_q && !(bp_q < rov_ext)) begin
          state_d = S_G_CHK;
        end else begin
          state_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (rd_size == '0) begin
          if (!pass2_q) begin
            pass2_d = 1'b1;
            bp_d    = bta_pkg::ListStart;
            state_d = S_A_RD;
          end else begin
            state_d = S_G_CHK;
          end
        end else if (!rd_used && rd_size >= need_q) begin
          rover_d = bp_q[15:0];
          size_d  = rd_size;
          state_d = S_C_W1;
        end else begin
          bp_d    = bp_q + rd_size;
          state_d = S_A_RD;
        end
      end
      S_G_CHK: begin
        if (gsize == '0 || gend > (PW+1)'(bta_pkg::HeapBytes)) begin
          stat_d  = bta_pkg::StatNoMem;
          state_d = S_DONE;
        end else begin
          size_d  = gsize[PW-1:0];
          bp_d    = brk_q;
          state_d = S_G_W1;
        end
      end
      S_G_W1: begin
        mem_we  = 1'b1;
        state_d = S_G_W2;
      end
      S_G_W2: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + size_q - PW'(8);
        state_d = S_G_W3;
      end
      S_G_W3: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + size_q - PW'(4);
        mem_wd  = bta_pkg::EpiTag;
        brk_d   = brk_q + size_q;
        state_d = S_M_RDP;
      end
      S_M_RDP: begin
        mem_ab  = bp_q - PW'(8);
        state_d = S_M_RDN;
      end
      S_M_RDN: begin
        prev_d  = rd_q;
        mem_ab  = bp_q + size_q - PW'(4);
        state_d = S_M_CHK;
      end
      S_M_CHK: begin
        if (!pfree && !nfree) begin
          state_d = free_q ? S_DONE : S_C_W1;
        end else begin
          bp_d   = merge_bp;
          size_d = merge_sz;
          // rover strictly inside the merged block moves to its start
          if (rov_ext > merge_bp && rov_ext < merge_bp + merge_sz) rover_d = merge_bp[15:0];
          state_d = S_M_WH;
        end
      end
      S_M_WH: begin
        mem_we  = 1'b1;
        state_d = S_M_WF;
      end
      S_M_WF: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + size_q - PW'(8);
        state_d = free_q ? S_DONE : S_C_W1;
      end
      S_C_W1: begin
        mem_we  = 1'b1;
        mem_wd  = (split ? need_q : size_q) | TW'(1);
        state_d = S_C_W2;
      end
      S_C_W2: begin
        mem_we = 1'b1;
        if (split) begin
          mem_ab  = bp_q + need_q - PW'(8);
          mem_wd  = need_q | TW'(1);
          state_d = S_C_W3;
        end else begin
          mem_ab  = bp_q + size_q - PW'(8);
          mem_wd  = size_q | TW'(1);
          res_d   = bp_q[15:0];
          state_d = S_DONE;
        end
      end
      S_C_W3: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + need_q - PW'(4);
        mem_wd  = rem_sz;
        state_d = S_C_W4;
      end
      S_C_W4: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + size_q - PW'(8);
        mem_wd  = rem_sz;
        res_d   = bp_q[15:0];
        state_d = S_DONE;
      end
      S_F_RD: begin
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (!rd_used || rd_size < bta_pkg::MinBlock || rd_size > brk_q - bp_q) begin
          state_d = S_DONE;
        end else begin
          size_d  = rd_size;
          state_d = S_F_WH;
        end
      end
      S_F_WH: begin
        mem_we  = 1'b1;
        state_d = S_F_WF;
      end
      S_F_WF: begin
        mem_we  = 1'b1;
        mem_ab  = bp_q + size_q - PW'(8);
        state_d = S_M_RDP;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // single-port tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) heap_mem[mem_idx] <= mem_wd;
    rd_q <= heap_mem[mem_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rover_q <= bta_pkg::ListStart[15:0];
      brk_q   <= bta_pkg::BreakReset;
      chunk_q <= bta_pkg::ChunkReset;
      pass2_q <= 1'b0;
      free_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rover_q <= rover_d;
      brk_q   <= brk_d;
      pass2_q <= pass2_d;
      free_q  <= free_d;
      done_q  <= done_d;
      if (psel && penable && pwrite && paddr == 2'd0) chunk_q <= pwdata[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q   <= bp_d;
    size_q <= size_d;
    need_q <= need_d;
    prev_q <= prev_d;
    res_q  <= res_d;
    stat_q <= stat_d;
  end

  assign busy_o          = state_q != S_IDLE;
  assign done_o          = done_q;
  assign result_offset_o = res_q;
  assign status_o        = stat_q;
  assign prdata          = {15'd0, chunk_q};
  assign pready          = 1'b1;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted command did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a command in flight");

  a_result_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_offset_o[2:0] == 3'b000)
               && (status_o == bta_pkg::StatOk || result_offset_o == '0))
    else $error("misaligned or nonzero offset with failing status");

  a_break_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q[2:0] == 3'b000 && brk_q <= PW'(bta_pkg::HeapBytes))
    else $error("heap break out of range");

endmodule
